// File: rtl/core/lsbsw_pkg.sv
// Shared constants and types for the LSB sync word detector
package lsbsw_pkg;

    // Mark geometry
    localparam int TRIG_LEN = 37;
    localparam int MARK_LEN = 85;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int THR_W    = 6;
    localparam int POS_W    = $clog2(MARK_LEN);
    localparam int FILL_W   = $clog2(TRIG_LEN + 1);
    localparam int CNT_W    = $clog2(TRIG_LEN + 1);
    localparam int CMP_W    = (CNT_W > THR_W) ? CNT_W : THR_W;

    // Agreement count tree: groups of cells summed, then the group sums added
    localparam int GROUP_W    = 8;
    localparam int NUM_GROUPS = (TRIG_LEN + GROUP_W - 1) / GROUP_W;
    localparam int GSUM_W     = $clog2(GROUP_W + 1);

    // Register reset values
    localparam logic [THR_W-1:0]    THR_RESET = THR_W'(37);
    localparam logic [TRIG_LEN-1:0] PAT_RESET = TRIG_LEN'(64'd136901025661);

    // APB register map: one 64-bit register every 8 bytes
    localparam int NUM_REGS   = 2;
    localparam int APB_DATA_W = 64;
    localparam int REG_SHIFT  = 3;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int APB_ADDR_W = REG_IDX_W + REG_SHIFT;

    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_PATTERN   = REG_IDX_W'(1);

    // Per-cycle control for one window cell
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

// File: rtl/core/lsbsw_sample_if.sv
// Sample request channel: valid/ready handshake with one audio sample
interface lsbsw_sample_if import lsbsw_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       stream_start;

    modport source (output valid, output sample, output stream_start, input ready);
    modport sink   (input valid, input sample, input stream_start, output ready);
endinterface

// File: rtl/core/lsbsw_mark_if.sv
// Mark bit request channel: valid/ready handshake with one extracted bit
interface lsbsw_mark_if import lsbsw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             mark_bit;
    logic [POS_W-1:0] bit_position;
    logic             last_bit;

    modport source (output valid, output mark_bit, output bit_position, output last_bit,
                    input ready);
    modport sink   (input valid, input mark_bit, input bit_position, input last_bit,
                    output ready);
endinterface

// File: rtl/core/lsb_sync_word_detector.sv
// LSB sync word detector: cell row, agreement tree, control and APB registers
// Path: a mark body bit goes from the input register to the output register; the
//   first bit of a mark also passes the window cells, evaluate and burst states.
// Flow: once the 37-bit window is full each sample waits for the evaluate state, and
//   a matching window is unloaded before input resumes; output stalls hold the input.
// Reset: clears window, fill count, mode and handshakes; threshold 37, default pattern.
module lsb_sync_word_detector import lsbsw_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    lsbsw_sample_if.sink          samples,
    lsbsw_mark_if.source          marks,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_EVAL  = 3'b010,
        ST_BURST = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                extracting_reg, extracting_next;
    logic [POS_W-1:0]    pos_reg, pos_next;

    logic                in_valid_reg, in_valid_next;
    logic                in_lsb_reg, in_lsb_next;
    logic                in_start_reg, in_start_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_bit_reg, out_bit_next;
    logic [POS_W-1:0]    out_pos_reg, out_pos_next;
    logic                out_last_reg, out_last_next;

    logic [THR_W-1:0]    thr_reg, thr_next;
    logic [TRIG_LEN-1:0] pat_reg, pat_next;

    logic [TRIG_LEN-1:0] win_bits;
    logic [TRIG_LEN-1:0] agree_next;
    logic [CNT_W-1:0]    agree_count;

    cell_ctrl_t          row_ctrl;
    cell_ctrl_t          first_ctrl;
    logic                first_in;

    logic                in_take;
    logic                emit;
    logic                emit_bit;
    logic [POS_W-1:0]    emit_pos;
    logic                out_free;
    logic [FILL_W-1:0]   fill_base;
    logic                cand_match;
    logic                cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;

    // Window cell row; cell TRIG_LEN-1 holds the earliest sample
    assign first_ctrl = '{shift: row_ctrl.shift, clear: 1'b0};

    for (genvar i = 0; i < TRIG_LEN; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            lsbsw_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (first_ctrl),
                .prev_bit    (first_in),
                .pattern_bit (pat_reg[i]),
                .win_bit     (win_bits[i]),
                .agree_next  (agree_next[i])
            );
        end
        else
        begin : g_rest
            lsbsw_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (row_ctrl),
                .prev_bit    (win_bits[i-1]),
                .pattern_bit (pat_reg[i]),
                .win_bit     (win_bits[i]),
                .agree_next  (agree_next[i])
            );
        end
    end

    lsbsw_count u_count (
        .clk         (clk),
        .rst_n       (rst_n),
        .agree_next  (agree_next),
        .agree_count (agree_count)
    );

    // Candidate check: earliest bit set and enough agreeing bits
    assign cand_match = win_bits[TRIG_LEN-1] &&
                        (CMP_W'(agree_count) >= CMP_W'(thr_reg));

    assign out_free = !out_valid_reg || marks.ready;

    // Main control
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        extracting_next = extracting_reg;
        pos_next        = pos_reg;
        in_take         = 1'b0;
        emit            = 1'b0;
        emit_bit        = 1'b0;
        emit_pos        = pos_reg;
        row_ctrl        = '{shift: 1'b0, clear: 1'b0};
        first_in        = in_lsb_reg;
        fill_base       = fill_reg;

        case (state_reg)
            ST_RUN:
            begin
                if (in_valid_reg)
                begin
                    if (extracting_reg && !in_start_reg)
                    begin
                        // Mark body: pass the sample LSB straight out
                        if (out_free)
                        begin
                            in_take  = 1'b1;
                            emit     = 1'b1;
                            emit_bit = in_lsb_reg;
                            if (pos_reg == POS_W'(MARK_LEN - 1))
                            begin
                                extracting_next = 1'b0;
                                pos_next        = '0;
                            end
                            else
                            begin
                                pos_next = pos_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        // Search: shift the sample into the window
                        in_take         = 1'b1;
                        row_ctrl        = '{shift: 1'b1, clear: in_start_reg};
                        extracting_next = 1'b0;
                        pos_next        = '0;
                        fill_base       = in_start_reg ? '0 : fill_reg;
                        if (fill_base < FILL_W'(TRIG_LEN))
                        begin
                            fill_next = fill_base + 1'b1;
                        end
                        else
                        begin
                            fill_next = fill_base;
                        end
                        if (fill_next == FILL_W'(TRIG_LEN))
                        begin
                            state_next = ST_EVAL;
                        end
                    end
                end
            end

            ST_EVAL:
            begin
                state_next = cand_match ? ST_BURST : ST_RUN;
            end

            ST_BURST:
            begin
                // Unload the window earliest first, zeros fill in behind
                if (out_free)
                begin
                    emit           = 1'b1;
                    emit_bit       = win_bits[TRIG_LEN-1];
                    row_ctrl       = '{shift: 1'b1, clear: 1'b0};
                    first_in       = 1'b0;
                    pos_next       = pos_reg + 1'b1;
                    if (pos_reg == POS_W'(TRIG_LEN - 1))
                    begin
                        state_next      = ST_RUN;
                        extracting_next = 1'b1;
                        fill_next       = '0;
                    end
                end
            end

            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Input register
    assign samples.ready = !in_valid_reg || in_take;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_lsb_next   = in_lsb_reg;
        in_start_next = in_start_reg;
        if (samples.valid && samples.ready)
        begin
            in_valid_next = 1'b1;
            in_lsb_next   = samples.sample[0];
            in_start_next = samples.stream_start;
        end
        else if (in_take)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_bit_next   = out_bit_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_bit_next   = emit_bit;
            out_pos_next   = emit_pos;
            out_last_next  = (emit_pos == POS_W'(MARK_LEN - 1));
        end
        else if (marks.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign marks.valid        = out_valid_reg;
    assign marks.mark_bit     = out_bit_reg;
    assign marks.bit_position = out_pos_reg;
    assign marks.last_bit     = out_last_reg;

    // APB register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = paddr[APB_ADDR_W-1:REG_SHIFT];

    always_comb
    begin
        thr_next = thr_reg;
        pat_next = pat_reg;
        if (cfg_write)
        begin
            case (reg_idx)
                REG_THRESHOLD: thr_next = pwdata[THR_W-1:0];
                REG_PATTERN:   pat_next = pwdata[TRIG_LEN-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_THRESHOLD: prdata = APB_DATA_W'(thr_reg);
            REG_PATTERN:   prdata = APB_DATA_W'(pat_reg);
            default:       prdata = '0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            fill_reg       <= '0;
            extracting_reg <= 1'b0;
            pos_reg        <= '0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            thr_reg        <= THR_RESET;
            pat_reg        <= PAT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            extracting_reg <= extracting_next;
            pos_reg        <= pos_next;
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            thr_reg        <= thr_next;
            pat_reg        <= pat_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_lsb_reg   <= in_lsb_next;
        in_start_reg <= in_start_next;
        out_bit_reg  <= out_bit_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
    end

endmodule

// File: rtl/core/lsbsw_cell.sv
// One window cell: holds one sample LSB and checks it against its pattern bit
module lsbsw_cell import lsbsw_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       prev_bit,
    input  logic       pattern_bit,
    output logic       win_bit,
    output logic       agree_next
);

    logic bit_reg;
    logic bit_next;

    // Take the neighbor's bit on a shift, or zero when the stream restarts
    always_comb
    begin
        bit_next = bit_reg;
        if (ctrl.shift)
        begin
            bit_next = ctrl.clear ? 1'b0 : prev_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    assign win_bit    = bit_reg;
    // Agreement of the value the cell will hold after this edge
    assign agree_next = ~(bit_next ^ pattern_bit);

endmodule

// File: rtl/core/lsbsw_count.sv
// Registered adder tree counting the window cells that agree with the pattern
module lsbsw_count import lsbsw_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [TRIG_LEN-1:0] agree_next,
    output logic [CNT_W-1:0]    agree_count
);

    logic [GSUM_W-1:0] gsum_reg  [NUM_GROUPS];
    logic [GSUM_W-1:0] gsum_next [NUM_GROUPS];

    // First level: popcount of each group of cells
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            gsum_next[g] = '0;
            for (int b = 0; b < GROUP_W; b++)
            begin
                if (g * GROUP_W + b < TRIG_LEN)
                begin
                    gsum_next[g] = gsum_next[g] + GSUM_W'(agree_next[g * GROUP_W + b]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                gsum_reg[g] <= '0;
            end
        end
        else
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                gsum_reg[g] <= gsum_next[g];
            end
        end
    end

    // Second level: add the registered group sums
    always_comb
    begin
        agree_count = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            agree_count = agree_count + CNT_W'(gsum_reg[g]);
        end
    end

endmodule
